>>> sv/hbn_pkg.sv
// Shared types and constants of the barrier tree node.
`default_nettype none
package hbn_pkg;
	localparam int MASK_W_MAX       = 32;
	localparam int ID_W             = 7;
	localparam int LVL_W            = 5;
	localparam int DEF_ID_COUNT     = 128;
	localparam int DEF_MASK_WIDTH   = 32;

	localparam logic [1:0] PORT_N = 2'd0;
	localparam logic [1:0] PORT_S = 2'd1;
	localparam logic [1:0] PORT_E = 2'd2;
	localparam logic [1:0] PORT_W = 2'd3;

	localparam logic [2:0] DEST_UP_EW = 3'd4;
	localparam logic [2:0] DEST_UP_NS = 3'd5;

	localparam logic CMD_REQ  = 1'b0;
	localparam logic CMD_WAKE = 1'b1;

	typedef struct packed {
		logic [2:0]            dest;
		logic                  is_wake;
		logic                  is_error;
		logic [MASK_W_MAX-1:0] level_mask;
		logic [ID_W-1:0]       resp_id;
		logic                  last_item;
	} hbn_res_t;
endpackage
`default_nettype wire

>>> sv/hbn_row_mem.sv
// Per-id state memory: one write port, one read port with registered data.
`default_nettype none
module hbn_row_mem #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 132,
	parameter int AW    = 7
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

>>> sv/hbn_decide.sv
// Read-modify-write logic: new row contents and the results of one item.
`default_nettype none
module hbn_decide
	import hbn_pkg::*;
#(
	parameter int ID_COUNT   = DEF_ID_COUNT,
	parameter int MASK_WIDTH = DEF_MASK_WIDTH,
	localparam int ROW_W     = 4 * MASK_WIDTH + 4
) (
	input  wire logic [LVL_W-1:0]      level_pos,
	input  wire logic                  cmd,
	input  wire logic [1:0]            port,
	input  wire logic                  parent_axis,
	input  wire logic                  sync_valid,
	input  wire logic [MASK_WIDTH-1:0] mask_in,
	input  wire logic [ID_W-1:0]       sync_id,
	input  wire logic [ROW_W-1:0]      rd_row,
	output logic                       wr_en,
	output logic      [ROW_W-1:0]      wr_row,
	output logic      [1:0]            res_cnt,
	output hbn_res_t                   res0,
	output hbn_res_t                   res1
);
	localparam int CNT_W = $clog2(ID_COUNT + 1);
	localparam int CMP_W = (CNT_W > ID_W) ? CNT_W : ID_W;
	localparam logic [MASK_WIDTH-1:0] FULL = {MASK_WIDTH{1'b1}};

	logic [MASK_WIDTH-1:0] m     [4];
	logic [MASK_WIDTH-1:0] m_new [4];
	logic [1:0]            cnt     [2];
	logic [1:0]            cnt_new [2];
	logic [MASK_WIDTH-1:0] lb;
	logic [MASK_WIDTH-1:0] above;
	logic                  axis;
	logic [1:0]            pa;
	logic [1:0]            pb;
	logic [1:0]            newcnt;
	logic                  hit;
	logic                  up;
	logic                  id_ok;
	logic                  pa_pend;
	logic                  pb_pend;
	logic [2:0]            up_dest;

	function automatic hbn_res_t mk_res(input logic [2:0] d, input logic w, input logic e,
			input logic [MASK_WIDTH-1:0] msk, input logic [ID_W-1:0] id);
		hbn_res_t r;
		r.dest       = d;
		r.is_wake    = w;
		r.is_error   = e;
		r.level_mask = MASK_W_MAX'(msk);
		r.resp_id    = id;
		r.last_item  = 1'b0;
		return r;
	endfunction

	assign id_ok = CMP_W'(sync_id) < CMP_W'(ID_COUNT);

	always_comb begin
		for (int i = 0; i < MASK_WIDTH; i++) begin
			lb[i]    = (LVL_W'(i) == level_pos);
			above[i] = (LVL_W'(i) > level_pos);
		end
		for (int p = 0; p < 4; p++) begin
			m[p] = rd_row[p*MASK_WIDTH +: MASK_WIDTH];
		end
		cnt[0] = rd_row[4*MASK_WIDTH +: 2];
		cnt[1] = rd_row[4*MASK_WIDTH+2 +: 2];

		axis    = (cmd == CMD_WAKE) ? parent_axis : port[1];
		pa      = axis ? PORT_W : PORT_N;
		pb      = axis ? PORT_E : PORT_S;
		up_dest = axis ? DEST_UP_NS : DEST_UP_EW;
		newcnt  = cnt[axis] + 2'd1;
		hit     = |(mask_in & lb);
		up      = |(mask_in & above);
		pa_pend = (m[pa] != FULL);
		pb_pend = (m[pb] != FULL);

		m_new   = m;
		cnt_new = cnt;
		wr_en   = 1'b0;
		res_cnt = 2'd0;
		res0    = '0;
		res1    = '0;

		if (cmd == CMD_REQ) begin
			if (!sync_valid || mask_in == '0 || !id_ok) begin
				res0    = mk_res(3'(port), 1'b0, 1'b1, '0, '0);
				res_cnt = 2'd1;
			end else if (hit) begin
				wr_en       = 1'b1;
				m_new[port] = mask_in;
				if (newcnt < 2'd2) begin
					cnt_new[axis] = newcnt;
				end else begin
					cnt_new[axis] = 2'd0;
					if (!up) begin
						// This level is the top of the barrier: wake both children.
						res0      = mk_res(3'(pa), 1'b1, 1'b0, m_new[pa], sync_id);
						res1      = mk_res(3'(pb), 1'b1, 1'b0, m_new[pb], sync_id);
						res_cnt   = 2'd2;
						m_new[pa] = FULL;
						m_new[pb] = FULL;
					end else begin
						res0    = mk_res(up_dest, 1'b0, 1'b0, mask_in, sync_id);
						res_cnt = 2'd1;
					end
				end
			end else if (up) begin
				wr_en       = 1'b1;
				m_new[port] = mask_in;
				res0        = mk_res(up_dest, 1'b0, 1'b0, mask_in, sync_id);
				res_cnt     = 2'd1;
			end else begin
				res0    = mk_res(3'(port), 1'b0, 1'b1, '0, '0);
				res_cnt = 2'd1;
			end
		end else if (id_ok) begin
			if (pa_pend) begin
				wr_en     = 1'b1;
				m_new[pa] = FULL;
			end
			if (pb_pend) begin
				wr_en     = 1'b1;
				m_new[pb] = FULL;
			end
			if (pa_pend && pb_pend) begin
				res0    = mk_res(3'(pa), 1'b1, 1'b0, lb, sync_id);
				res1    = mk_res(3'(pb), 1'b1, 1'b0, lb, sync_id);
				res_cnt = 2'd2;
			end else if (pa_pend) begin
				res0    = mk_res(3'(pa), 1'b1, 1'b0, lb, sync_id);
				res_cnt = 2'd1;
			end else if (pb_pend) begin
				res0    = mk_res(3'(pb), 1'b1, 1'b0, lb, sync_id);
				res_cnt = 2'd1;
			end
		end

		res0.last_item = (res_cnt == 2'd1);
		res1.last_item = 1'b1;

		for (int p = 0; p < 4; p++) begin
			wr_row[p*MASK_WIDTH +: MASK_WIDTH] = m_new[p];
		end
		wr_row[4*MASK_WIDTH +: 2]   = cnt_new[0];
		wr_row[4*MASK_WIDTH+2 +: 2] = cnt_new[1];
	end
endmodule
`default_nettype wire

>>> sv/hbn_out_buf.sv
// Two-entry result buffer that separates the output channel from the core.
`default_nettype none
module hbn_out_buf
	import hbn_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       load,
	input  wire logic [1:0] res_cnt,
	input  wire hbn_res_t   res0,
	input  wire hbn_res_t   res1,
	input  wire logic       rsp_ready,
	output logic            load_ok,
	output logic            rsp_valid,
	output hbn_res_t        head
);
	hbn_res_t   e0_q;
	hbn_res_t   e1_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign rsp_valid = (cnt_q != 2'd0);
	assign pop       = rsp_valid && rsp_ready;
	// New results are taken only once the buffer is empty after this cycle's pop.
	assign load_ok   = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);
	assign head      = e0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load && load_ok) begin
			cnt_q <= res_cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && load_ok) begin
			e0_q <= res0;
			e1_q <= res1;
		end else if (pop) begin
			e0_q <= e1_q;
		end
	end
endmodule
`default_nettype wire

>>> sv/hierarchical_barrier_node.sv
// Barrier tree node: per-id pending masks and arrival counts in one row memory.
// The item's row is read when it is accepted; its results are computed in ST_CALC and
// loaded into the output buffer, which offers them. Items are taken one at a time: a
// new one is accepted only in ST_IDLE; ST_CALC waits until the buffer takes results.
// Reset: a clearing pass writes each of the ID_COUNT rows of the memory; no item is
// accepted during it, configuration writes are taken; level_pos resets to 0.
`default_nettype none
module hierarchical_barrier_node
	import hbn_pkg::*;
#(
	parameter int ID_COUNT   = DEF_ID_COUNT,
	parameter int MASK_WIDTH = DEF_MASK_WIDTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [LVL_W-1:0]      cfg_wdata,
	input  wire logic                  req_valid,
	output logic                       req_ready,
	input  wire logic                  cmd,
	input  wire logic [1:0]            port,
	input  wire logic                  parent_axis,
	input  wire logic                  sync_valid,
	input  wire logic [MASK_W_MAX-1:0] aggr_mask,
	input  wire logic [ID_W-1:0]       sync_id,
	output logic                       rsp_valid,
	input  wire logic                  rsp_ready,
	output logic      [2:0]            dest,
	output logic                       is_wake,
	output logic                       is_error,
	output logic      [MASK_W_MAX-1:0] level_mask,
	output logic      [ID_W-1:0]       resp_id,
	output logic                       last_item
);
	localparam int AW    = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
	localparam int EXT_W = (AW > ID_W) ? AW : ID_W;
	localparam int ROW_W = 4 * MASK_WIDTH + 4;

	typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_CALC} state_t;

	state_t                state_q;
	logic [AW-1:0]         clr_q;
	logic [LVL_W-1:0]      level_pos_q;
	logic                  cmd_q;
	logic [1:0]            port_q;
	logic                  axis_q;
	logic                  sv_q;
	logic [MASK_WIDTH-1:0] mask_q;
	logic [ID_W-1:0]       id_q;

	logic                  accept;
	logic [EXT_W-1:0]      in_id_ext;
	logic [EXT_W-1:0]      q_id_ext;
	logic [AW-1:0]         raddr;
	logic [AW-1:0]         item_addr;
	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	logic [ROW_W-1:0]      mem_wdata;
	logic [ROW_W-1:0]      rd_row;
	logic                  dec_wr_en;
	logic [ROW_W-1:0]      dec_row;
	logic [1:0]            res_cnt;
	hbn_res_t              res0;
	hbn_res_t              res1;
	hbn_res_t              head;
	logic                  load;
	logic                  load_ok;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign in_id_ext = EXT_W'(sync_id);
	assign q_id_ext  = EXT_W'(id_q);
	assign raddr     = in_id_ext[AW-1:0];
	assign item_addr = q_id_ext[AW-1:0];
	assign load      = (state_q == ST_CALC);

	always_comb begin
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = {4'b0000, {(4 * MASK_WIDTH){1'b1}}};
		end else begin
			mem_we    = load && load_ok && dec_wr_en;
			mem_waddr = item_addr;
			mem_wdata = dec_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (clr_q == AW'(ID_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
					clr_q <= clr_q + AW'(1);
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					if (load_ok) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_pos_q <= '0;
		end else if (cfg_we) begin
			level_pos_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd;
			port_q <= port;
			axis_q <= parent_axis;
			sv_q   <= sync_valid;
			mask_q <= aggr_mask[MASK_WIDTH-1:0];
			id_q   <= sync_id;
		end
	end

	hbn_row_mem #(
		.DEPTH (ID_COUNT),
		.WIDTH (ROW_W),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (accept),
		.raddr (raddr),
		.rdata (rd_row)
	);

	hbn_decide #(
		.ID_COUNT   (ID_COUNT),
		.MASK_WIDTH (MASK_WIDTH)
	) u_decide (
		.level_pos   (level_pos_q),
		.cmd         (cmd_q),
		.port        (port_q),
		.parent_axis (axis_q),
		.sync_valid  (sv_q),
		.mask_in     (mask_q),
		.sync_id     (id_q),
		.rd_row      (rd_row),
		.wr_en       (dec_wr_en),
		.wr_row      (dec_row),
		.res_cnt     (res_cnt),
		.res0        (res0),
		.res1        (res1)
	);

	hbn_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.res_cnt   (res_cnt),
		.res0      (res0),
		.res1      (res1),
		.rsp_ready (rsp_ready),
		.load_ok   (load_ok),
		.rsp_valid (rsp_valid),
		.head      (head)
	);

	assign dest       = head.dest;
	assign is_wake    = head.is_wake;
	assign is_error   = head.is_error;
	assign level_mask = head.level_mask;
	assign resp_id    = head.resp_id;
	assign last_item  = head.last_item;
endmodule
`default_nettype wire

>>> tb/hbn_checker.sv
// Checker for the barrier tree node: predicts results of accepted items and compares them.
module hbn_checker
	import hbn_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [LVL_W-1:0]      cfg_wdata,
	input  wire logic                  req_valid,
	input  wire logic                  req_ready,
	input  wire logic                  cmd,
	input  wire logic [1:0]            port,
	input  wire logic                  parent_axis,
	input  wire logic                  sync_valid,
	input  wire logic [MASK_W_MAX-1:0] aggr_mask,
	input  wire logic [ID_W-1:0]       sync_id,
	input  wire logic                  rsp_valid,
	input  wire logic                  rsp_ready,
	input  wire logic [2:0]            dest,
	input  wire logic                  is_wake,
	input  wire logic                  is_error,
	input  wire logic [MASK_W_MAX-1:0] level_mask,
	input  wire logic [ID_W-1:0]       resp_id,
	input  wire logic                  last_item,
	output int                         fail_count,
	output int                         results_waiting
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [MASK_W_MAX-1:0] EMPTY_SLOT = '1;

	logic [MASK_W_MAX-1:0] held_mask [4][DEF_ID_COUNT];
	logic [1:0]            pair_arrivals [2][DEF_ID_COUNT];
	logic [LVL_W-1:0]      level_sel;
	hbn_res_t              barrier_results_q[$];

	task automatic flag_error(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		fail_count++;
	endtask

	function automatic int highest_bit(input logic [MASK_W_MAX-1:0] m);
		for (int b = MASK_W_MAX - 1; b >= 0; b--) begin
			if (m[b])
				return b;
		end
		return -1;
	endfunction

	task automatic push_result(input logic [2:0] d, input logic wk, input logic er,
			input logic [MASK_W_MAX-1:0] m, input logic [ID_W-1:0] id);
		hbn_res_t r;
		r.dest       = d;
		r.is_wake    = wk;
		r.is_error   = er;
		r.level_mask = m;
		r.resp_id    = id;
		r.last_item  = 1'b0;
		barrier_results_q.push_back(r);
	endtask

	task automatic predict_barrier();
		logic                  ew;
		logic [1:0]            pa, pb;
		logic [MASK_W_MAX-1:0] lb, m;
		int                    msb, lvl, count_before;
		hbn_res_t              tail;
		count_before = barrier_results_q.size();
		lb = {{(MASK_W_MAX-1){1'b0}}, 1'b1} << level_sel;
		lvl = int'(level_sel);
		ew = (cmd == CMD_WAKE) ? parent_axis : port[1];
		pa = ew ? PORT_W : PORT_N;
		pb = ew ? PORT_E : PORT_S;
		m = aggr_mask;
		msb = highest_bit(m);
		if (cmd == CMD_WAKE) begin
			// Only children still holding a mask for this id are woken.
			if (held_mask[pa][sync_id] != EMPTY_SLOT) begin
				push_result({1'b0, pa}, 1'b1, 1'b0, lb, sync_id);
				held_mask[pa][sync_id] = EMPTY_SLOT;
			end
			if (held_mask[pb][sync_id] != EMPTY_SLOT) begin
				push_result({1'b0, pb}, 1'b1, 1'b0, lb, sync_id);
				held_mask[pb][sync_id] = EMPTY_SLOT;
			end
		end else if (!sync_valid || m == '0) begin
			push_result({1'b0, port}, 1'b0, 1'b1, '0, '0);
		end else if ((m & lb) != '0) begin
			held_mask[port][sync_id] = m;
			pair_arrivals[ew][sync_id] = pair_arrivals[ew][sync_id] + 2'd1;
			if (pair_arrivals[ew][sync_id] >= 2'd2) begin
				pair_arrivals[ew][sync_id] = 2'd0;
				if (msb == lvl) begin
					push_result({1'b0, pa}, 1'b1, 1'b0, held_mask[pa][sync_id], sync_id);
					push_result({1'b0, pb}, 1'b1, 1'b0, held_mask[pb][sync_id], sync_id);
					held_mask[pa][sync_id] = EMPTY_SLOT;
					held_mask[pb][sync_id] = EMPTY_SLOT;
				end else begin
					push_result(ew ? DEST_UP_NS : DEST_UP_EW, 1'b0, 1'b0, m, sync_id);
				end
			end
		end else if (msb > lvl) begin
			held_mask[port][sync_id] = m;
			push_result(ew ? DEST_UP_NS : DEST_UP_EW, 1'b0, 1'b0, m, sync_id);
		end else begin
			push_result({1'b0, port}, 1'b0, 1'b1, '0, '0);
		end
		if (barrier_results_q.size() > count_before) begin
			tail = barrier_results_q.pop_back();
			tail.last_item = 1'b1;
			barrier_results_q.push_back(tail);
		end
	endtask

	task automatic check_result();
		hbn_res_t want;
		if (barrier_results_q.size() == 0) begin
			flag_error($sformatf("result with none expected: dest %0d id %0d", dest, resp_id));
		end else begin
			want = barrier_results_q.pop_front();
			if (dest !== want.dest)
				flag_error($sformatf("dest %0d, expected %0d", dest, want.dest));
			if (is_wake !== want.is_wake)
				flag_error($sformatf("is_wake %0b, expected %0b", is_wake, want.is_wake));
			if (is_error !== want.is_error)
				flag_error($sformatf("is_error %0b, expected %0b", is_error, want.is_error));
			if (level_mask !== want.level_mask)
				flag_error($sformatf("level_mask %h, expected %h", level_mask, want.level_mask));
			if (resp_id !== want.resp_id)
				flag_error($sformatf("resp_id %0d, expected %0d", resp_id, want.resp_id));
			if (last_item !== want.last_item)
				flag_error($sformatf("last_item %0b, expected %0b", last_item, want.last_item));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < 4; p++) begin
				for (int i = 0; i < DEF_ID_COUNT; i++)
					held_mask[p][i] = EMPTY_SLOT;
			end
			for (int a = 0; a < 2; a++) begin
				for (int i = 0; i < DEF_ID_COUNT; i++)
					pair_arrivals[a][i] = 2'd0;
			end
			level_sel = '0;
			barrier_results_q.delete();
			fail_count = 0;
			results_waiting <= 0;
		end else begin
			if (cfg_we)
				level_sel = cfg_wdata;
			if (rsp_valid && rsp_ready)
				check_result();
			if (req_valid && req_ready)
				predict_barrier();
			results_waiting <= barrier_results_q.size();
		end
	end
endmodule

>>> tb/hierarchical_barrier_node_tb.sv
// Top of the barrier tree node testbench: clock, reset, stimulus and verdict.
module hierarchical_barrier_node_tb
	import hbn_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic AXIS_NS      = 1'b0;
	localparam logic AXIS_EW      = 1'b1;
	localparam int   IDLE_PCT     = 28;
	localparam int   DRAIN_CYCLES = 8;
	localparam int   QUIET_LIMIT  = 4000;
	localparam int   PHASE_ITEMS  = 360;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [LVL_W-1:0]      cfg_wdata;
	logic                  req_valid;
	logic                  req_ready;
	logic                  cmd;
	logic [1:0]            port;
	logic                  parent_axis;
	logic                  sync_valid;
	logic [MASK_W_MAX-1:0] aggr_mask;
	logic [ID_W-1:0]       sync_id;
	logic                  rsp_valid;
	logic                  rsp_ready = 1'b0;
	logic [2:0]            dest;
	logic                  is_wake;
	logic                  is_error;
	logic [MASK_W_MAX-1:0] level_mask;
	logic [ID_W-1:0]       resp_id;
	logic                  last_item;
	int                    fail_count;
	int                    results_waiting;
	int                    quiet = 0;
	int                    items_sent = 0;
	int                    lvl = 0;
	bit                    calm = 1'b0;

	hierarchical_barrier_node dut (.*);

	hbn_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver stalls at random, except during the calm stretch.
	always @(posedge clk)
		rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);

	// Ends the run when nothing moves on either channel for too long.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	function automatic logic [MASK_W_MAX-1:0] pick_barrier_mask(input int at, input bit peak);
		logic [MASK_W_MAX-1:0] lower, upper;
		lower = $urandom() & ((32'd1 << at) - 32'd1);
		if ($urandom_range(1))
			lower = '0;
		upper = '0;
		if (!peak && at < MASK_W_MAX - 1) begin
			upper = $urandom() << (at + 1);
			if (upper == '0)
				upper = 32'h8000_0000;
		end
		return lower | (32'd1 << at) | upper;
	endfunction

	task automatic send_item(input logic c, input logic [1:0] p, input logic ax,
			input logic sv, input logic [MASK_W_MAX-1:0] m, input logic [ID_W-1:0] id);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid   <= 1'b1;
		cmd         <= c;
		port        <= p;
		parent_axis <= ax;
		sync_valid  <= sv;
		aggr_mask   <= m;
		sync_id     <= id;
		do @(posedge clk); while (!req_ready);
		items_sent++;
	endtask

	// Holds the sender off until every expected result is back and the block is quiet.
	task automatic settle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (results_waiting != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_level(input int v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v[LVL_W-1:0];
		lvl = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Both children of a pair (or one twice) arrive at one id, maybe then the parent wake.
	task automatic send_pair();
		logic           ew;
		logic [ID_W-1:0] id;
		logic [1:0]     first, second, t;
		bit             peak;
		ew = 1'($urandom_range(1));
		id = ID_W'($urandom_range(DEF_ID_COUNT - 1));
		peak = 1'($urandom_range(1));
		first = ew ? PORT_E : PORT_N;
		second = ew ? PORT_W : PORT_S;
		if ($urandom_range(1)) begin
			t = first;
			first = second;
			second = t;
		end
		if ($urandom_range(19) == 0)
			second = first;
		send_item(CMD_REQ, first, 1'($urandom_range(1)), 1'b1,
			pick_barrier_mask(lvl, peak), id);
		send_item(CMD_REQ, second, 1'($urandom_range(1)), 1'b1,
			pick_barrier_mask(lvl, peak), id);
		if (!peak || $urandom_range(3) == 0)
			send_item(CMD_WAKE, 2'($urandom_range(3)), ew, 1'($urandom_range(1)),
				$urandom(), id);
	endtask

	task automatic send_noise();
		logic [MASK_W_MAX-1:0] m;
		case ($urandom_range(3))
			0: m = $urandom();
			1: m = '0;
			2: m = '1;
			default: m = 32'd1 << $urandom_range(MASK_W_MAX - 1);
		endcase
		send_item(1'($urandom_range(1)), 2'($urandom_range(3)), 1'($urandom_range(1)),
			1'($urandom_range(1)), m, ID_W'($urandom_range(DEF_ID_COUNT - 1)));
	endtask

	initial begin
		int phase_level [5];
		int goal;
		int pick;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_wdata   = '0;
		req_valid   = 1'b0;
		cmd         = CMD_REQ;
		port        = PORT_N;
		parent_axis = AXIS_NS;
		sync_valid  = 1'b0;
		aggr_mask   = '0;
		sync_id     = '0;
		phase_level = '{0, MASK_W_MAX - 1, 0, 0, 3};
		phase_level[2] = $urandom_range(1, MASK_W_MAX - 2);
		phase_level[3] = $urandom_range(1, MASK_W_MAX - 2);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at level 3.
		write_level(3);
		send_item(CMD_REQ, PORT_N, AXIS_NS, 1'b0, 32'h0000_0008, 7'd5);
		send_item(CMD_REQ, PORT_S, AXIS_NS, 1'b1, 32'h0000_0000, 7'd6);
		send_item(CMD_REQ, PORT_E, AXIS_EW, 1'b1, 32'h0000_0007, 7'd7);
		send_item(CMD_REQ, PORT_N, AXIS_NS, 1'b1, 32'h0000_0008, 7'd10);
		send_item(CMD_REQ, PORT_S, AXIS_EW, 1'b1, 32'h0000_000C, 7'd10);
		send_item(CMD_REQ, PORT_E, AXIS_NS, 1'b1, 32'h0000_0018, 7'd20);
		send_item(CMD_REQ, PORT_W, AXIS_EW, 1'b1, 32'h0000_0018, 7'd20);
		send_item(CMD_WAKE, PORT_S, AXIS_EW, 1'b0, 32'h0000_0000, 7'd20);
		send_item(CMD_REQ, PORT_N, AXIS_NS, 1'b1, 32'h8000_0000, 7'd30);
		send_item(CMD_WAKE, PORT_W, AXIS_NS, 1'b1, 32'hFFFF_FFFF, 7'd30);
		send_item(CMD_WAKE, PORT_N, AXIS_NS, 1'b1, 32'h0000_0000, 7'd31);
		// An all-ones mask is stored but reads back as an empty slot.
		send_item(CMD_REQ, PORT_W, AXIS_EW, 1'b1, 32'hFFFF_FFFF, 7'd40);
		send_item(CMD_REQ, PORT_W, AXIS_EW, 1'b1, 32'hFFFF_FFFF, 7'd40);
		send_item(CMD_REQ, PORT_E, AXIS_EW, 1'b1, 32'h0000_0008, 7'd41);
		send_item(CMD_REQ, PORT_E, AXIS_EW, 1'b1, 32'h0000_0008, 7'd41);
		send_item(CMD_WAKE, PORT_E, AXIS_EW, 1'b0, 32'h0000_0000, 7'd40);
		send_item(CMD_REQ, PORT_S, AXIS_NS, 1'b1, 32'hFFFF_FFF7, 7'd127);
		send_item(CMD_WAKE, PORT_N, AXIS_NS, 1'b1, 32'h5555_5555, 7'd127);
		send_item(CMD_REQ, PORT_N, AXIS_EW, 1'b1, 32'h0000_0008, 7'd0);
		send_item(CMD_REQ, PORT_S, AXIS_NS, 1'b1, 32'h0000_0008, 7'd0);
		send_item(CMD_REQ, PORT_W, AXIS_EW, 1'b1, 32'h0000_0004, 7'd0);

		for (int ph = 0; ph < 5; ph++) begin
			settle();
			write_level(phase_level[ph]);
			calm <= (ph == 2);
			goal = items_sent + PHASE_ITEMS;
			while (items_sent < goal) begin
				pick = $urandom_range(99);
				if (pick < 55)
					send_pair();
				else if (pick < 70)
					send_item(CMD_REQ, 2'($urandom_range(3)), 1'($urandom_range(1)), 1'b1,
						pick_barrier_mask(lvl, 1'($urandom_range(1))),
						ID_W'($urandom_range(DEF_ID_COUNT - 1)));
				else if (pick < 85)
					send_item(CMD_WAKE, 2'($urandom_range(3)), 1'($urandom_range(1)),
						1'($urandom_range(1)), $urandom(),
						ID_W'($urandom_range(DEF_ID_COUNT - 1)));
				else
					send_noise();
			end
		end

		settle();
		@(negedge clk);
		if (fail_count == 0 && results_waiting == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
